/* rtl/summary_prefix_table_macros.svh */
// assertion macros used by the checker file of the prefix table
`ifndef SUMMARY_PREFIX_TABLE_MACROS_SVH
`define SUMMARY_PREFIX_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk, idle during reset
`define SPT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prefix table check failed");

// next-cycle implication, sampled on clk, idle during reset
`define SPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prefix table check failed");

`endif

/* rtl/spt_pkg.sv */
// types, codes and microcode program of the summary prefix table
`timescale 1ns / 1ps
`default_nettype none
package spt_pkg;

  localparam int ENTRY_W = 65;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_MATCH  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_UPDATED = 3'd1,
    ST_REMOVED = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_FULL    = 3'd4,
    ST_HIT     = 3'd5,
    ST_MISS    = 3'd6
  } status_t;

  // microcode step addresses
  typedef enum logic [1:0] {
    STEP_IDLE   = 2'd0,
    STEP_SCAN   = 2'd1,
    STEP_DRAIN  = 2'd2,
    STEP_COMMIT = 2'd3
  } step_t;

  // jump conditions
  typedef enum logic [1:0] {
    COND_ALWAYS   = 2'd0,
    COND_ACCEPT   = 2'd1,
    COND_LAST     = 2'd2,
    COND_OUT_FREE = 2'd3
  } cond_t;

  // one control word
  typedef struct packed {
    logic  ready;
    logic  scan;
    logic  commit;
    cond_t cond;
    step_t target;
  } ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic scan_last;
    logic out_free;
  } flags_t;

  // control store: jump to target when cond holds, else repeat the step
  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    c = '0;
    unique case (s)
      STEP_IDLE: begin
        c.ready  = 1'b1;
        c.cond   = COND_ACCEPT;
        c.target = STEP_SCAN;
      end
      STEP_SCAN: begin
        c.scan   = 1'b1;
        c.cond   = COND_LAST;
        c.target = STEP_DRAIN;
      end
      STEP_DRAIN: begin
        c.cond   = COND_ALWAYS;
        c.target = STEP_COMMIT;
      end
      STEP_COMMIT: begin
        c.commit = 1'b1;
        c.cond   = COND_OUT_FREE;
        c.target = STEP_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* rtl/spt_if.sv */
// request and response channel interfaces of the summary prefix table
`timescale 1ns / 1ps
`default_nettype none
interface spt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] prefix_addr;
  logic [31:0] prefix_mask;
  logic        no_advertise;

  modport source (output valid, opcode, prefix_addr, prefix_mask, no_advertise,
                  input ready);
  modport sink (input valid, opcode, prefix_addr, prefix_mask, no_advertise,
                output ready);
endinterface

interface spt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  entry_index;
  logic [31:0] entry_addr;
  logic [31:0] entry_mask;
  logic        entry_no_adv;
  logic        any_valid;

  modport source (output valid, status, entry_index, entry_addr, entry_mask,
                  entry_no_adv, any_valid, input ready);
  modport sink (input valid, status, entry_index, entry_addr, entry_mask,
                entry_no_adv, any_valid, output ready);
endinterface
`default_nettype wire

/* rtl/spt_sequencer.sv */
// microcode step counter with conditional jumps
`timescale 1ns / 1ps
`default_nettype none
module spt_sequencer (
  input  logic           clk,
  input  logic           rst,
  input  spt_pkg::flags_t flags,
  output spt_pkg::ctrl_t  ctrl
);

  spt_pkg::step_t pc;
  spt_pkg::step_t pc_next;
  logic           take;

  // control word lookup
  always_comb begin
    ctrl = spt_pkg::ucode(pc);
  end

  // next step
  always_comb begin
    unique case (ctrl.cond)
      spt_pkg::COND_ALWAYS:   take = 1'b1;
      spt_pkg::COND_ACCEPT:   take = flags.in_valid;
      spt_pkg::COND_LAST:     take = flags.scan_last;
      spt_pkg::COND_OUT_FREE: take = flags.out_free;
    endcase
    pc_next = take ? ctrl.target : pc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= spt_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/spt_datapath.sv */
// prefix storage, scan compare, result register
`timescale 1ns / 1ps
`default_nettype none
module spt_datapath #(
  parameter int ENTRIES = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  spt_pkg::ctrl_t  ctrl,
  output spt_pkg::flags_t flags,
  spt_req_if.sink         req,
  spt_rsp_if.source       rsp
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // query word
  spt_pkg::opcode_t q_op;
  logic [31:0]      q_addr;
  logic [31:0]      q_mask;
  logic             q_nadv;

  // scan pointer and read stage
  logic [IDX_W-1:0]           idx;
  logic [IDX_W-1:0]           rd_idx;
  logic                       rd_vld;
  logic [spt_pkg::ENTRY_W-1:0] rd_data;
  logic [spt_pkg::ENTRY_W-1:0] mem [ENTRIES];
  logic [31:0]                rd_addr;
  logic [31:0]                rd_mask;
  logic                       rd_nadv;

  logic [ENTRIES-1:0] valid_bits;
  logic [CNT_W-1:0]   valid_cnt;
  logic [CNT_W-1:0]   valid_cnt_next;

  // first hit and first free slot
  logic             found;
  logic [IDX_W-1:0] hit_idx;
  logic [31:0]      hit_addr;
  logic [31:0]      hit_mask;
  logic             hit_nadv;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  logic vbit;
  logic exact;
  logic covers;
  logic sel;
  logic accept;
  logic commit_go;
  logic out_free;

  // commit decision
  spt_pkg::status_t            res_status;
  logic [IDX_W-1:0]            res_idx;
  logic [31:0]                 res_addr;
  logic [31:0]                 res_mask;
  logic                        res_nadv;
  logic                        res_slot;
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_idx;
  logic [spt_pkg::ENTRY_W-1:0] wr_data;
  logic                        set_v;
  logic                        clr_v;
  logic [IDX_W+3:0]            idx_ext;

  assign req.ready = ctrl.ready;
  assign accept    = req.valid & ctrl.ready;
  assign out_free  = ~rsp.valid | rsp.ready;
  assign commit_go = ctrl.commit & out_free;

  assign flags.in_valid  = req.valid;
  assign flags.scan_last = (idx == IDX_W'(ENTRIES - 1));
  assign flags.out_free  = out_free;

  assign rd_addr = rd_data[64:33];
  assign rd_mask = rd_data[32:1];
  assign rd_nadv = rd_data[0];

  always_ff @(posedge clk) begin
    if (accept) begin
      q_op   <= spt_pkg::opcode_t'(req.opcode);
      q_addr <= req.prefix_addr;
      q_mask <= req.prefix_mask;
      q_nadv <= req.no_advertise;
    end
  end

  // storage: one write port at commit, one registered read port for the scan
  always_ff @(posedge clk) begin
    if (wr_en && commit_go) begin
      mem[wr_idx] <= wr_data;
    end
    if (ctrl.scan) begin
      rd_data <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      rd_idx <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= ctrl.scan;
      if (accept) begin
        idx <= '0;
      end else if (ctrl.scan) begin
        idx    <= idx + IDX_W'(1);
        rd_idx <= idx;
      end
    end
  end

  // entry compare against the query
  assign vbit   = valid_bits[rd_idx];
  assign exact  = vbit && (rd_addr == q_addr) && (rd_mask == q_mask);
  assign covers = vbit && (rd_mask <= q_mask) && (((rd_addr ^ q_addr) & rd_mask) == 32'd0);
  assign sel    = (q_op == spt_pkg::OP_MATCH) ? covers : exact;

  always_ff @(posedge clk) begin
    if (rst) begin
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (accept) begin
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (rd_vld) begin
      if (sel && !found) begin
        found <= 1'b1;
      end
      if (!vbit && !free_found) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld && sel && !found) begin
      hit_idx  <= rd_idx;
      hit_addr <= rd_addr;
      hit_mask <= rd_mask;
      hit_nadv <= rd_nadv;
    end
    if (rd_vld && !vbit && !free_found) begin
      free_idx <= rd_idx;
    end
  end

  always_comb begin
    res_status = spt_pkg::ST_MISS;
    res_idx    = hit_idx;
    res_addr   = hit_addr;
    res_mask   = hit_mask;
    res_nadv   = hit_nadv;
    res_slot   = 1'b0;
    wr_en      = 1'b0;
    wr_idx     = hit_idx;
    wr_data    = {hit_addr, hit_mask, hit_nadv | q_nadv};
    set_v      = 1'b0;
    clr_v      = 1'b0;
    unique case (q_op)
      spt_pkg::OP_ADD: begin
        if (found) begin
          res_status = spt_pkg::ST_UPDATED;
          res_nadv   = hit_nadv | q_nadv;
          res_slot   = 1'b1;
          wr_en      = 1'b1;
        end else if (free_found) begin
          res_status = spt_pkg::ST_ADDED;
          res_idx    = free_idx;
          res_addr   = q_addr;
          res_mask   = q_mask;
          res_nadv   = q_nadv;
          res_slot   = 1'b1;
          wr_en      = 1'b1;
          wr_idx     = free_idx;
          wr_data    = {q_addr, q_mask, q_nadv};
          set_v      = 1'b1;
        end else begin
          res_status = spt_pkg::ST_FULL;
        end
      end
      spt_pkg::OP_REMOVE: begin
        if (found) begin
          res_status = spt_pkg::ST_REMOVED;
          res_slot   = 1'b1;
          clr_v      = 1'b1;
        end else begin
          res_status = spt_pkg::ST_ABSENT;
        end
      end
      spt_pkg::OP_MATCH: begin
        if (found) begin
          res_status = spt_pkg::ST_HIT;
          res_slot   = 1'b1;
        end
      end
      default: begin
        res_status = spt_pkg::ST_MISS;
      end
    endcase
    valid_cnt_next = valid_cnt + CNT_W'(set_v) - CNT_W'(clr_v);
    idx_ext        = {4'd0, res_idx};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      valid_cnt  <= '0;
    end else if (commit_go) begin
      valid_cnt <= valid_cnt_next;
      if (set_v) begin
        valid_bits[wr_idx] <= 1'b1;
      end
      if (clr_v) begin
        valid_bits[hit_idx] <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (commit_go) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      rsp.status       <= res_status;
      rsp.entry_index  <= res_slot ? idx_ext[3:0] : 4'd0;
      rsp.entry_addr   <= res_slot ? res_addr : 32'd0;
      rsp.entry_mask   <= res_slot ? res_mask : 32'd0;
      rsp.entry_no_adv <= res_slot & res_nadv;
      rsp.any_valid    <= (valid_cnt_next != '0);
    end
  end

endmodule
`default_nettype wire

/* rtl/summary_prefix_table.sv */
// top level of the summary prefix table
// usage:
//   req channel carries one request word: opcode (add, remove, match),
//   prefix_addr, prefix_mask and no_advertise
//   rsp channel returns one word per request: status, entry_index,
//   entry_addr, entry_mask, entry_no_adv and any_valid
//   a request is taken on a clk edge with valid and ready both high
// sequence:
//   the sequencer scans all ENTRIES slots through one registered read port,
//   one slot per cycle, then passes through a drain step for the read
//   latency and a commit step that writes the response word
//   a new request is taken only once the commit of the last one is done
// reset:
//   rst (synchronous) clears all slot valid bits at once and the fill count;
//   the table is usable in the cycle after reset
// backpressure:
//   the response sits in an output register; the next request is taken and
//   scanned while it waits, and the commit step holds until the register frees
`timescale 1ns / 1ps
`default_nettype none
module summary_prefix_table #(
  parameter int ENTRIES = 16
) (
  input  logic      clk,
  input  logic      rst,
  spt_req_if.sink   req,
  spt_rsp_if.source rsp
);

  spt_pkg::ctrl_t  ctrl;
  spt_pkg::flags_t flags;

  // control store and step counter
  spt_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // slot storage, compare and response register
  spt_datapath #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .flags (flags),
    .req   (req),
    .rsp   (rsp)
  );

endmodule
`default_nettype wire

/* rtl/spt_checker.sv */
// port-level checks of the summary prefix table and their bind
`timescale 1ns / 1ps
`default_nettype none
`include "summary_prefix_table_macros.svh"
module spt_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [2:0]  status,
  input logic [3:0]  entry_index,
  input logic [31:0] entry_addr,
  input logic [31:0] entry_mask,
  input logic        entry_no_adv
);

  logic        stalled;
  logic        no_slot;
  logic        slot_zero;
  logic        req_take;
  logic [71:0] rsp_word;

  assign stalled   = rsp_valid && !rsp_ready;
  assign req_take  = req_valid && req_ready;
  assign rsp_word  = {status, entry_index, entry_addr, entry_mask, entry_no_adv};
  assign no_slot   = rsp_valid && (status == spt_pkg::ST_ABSENT ||
                                   status == spt_pkg::ST_FULL ||
                                   status == spt_pkg::ST_MISS);
  assign slot_zero = (entry_index == 4'd0) && (entry_addr == 32'd0) &&
                     (entry_mask == 32'd0) && !entry_no_adv;

  // a stalled response word holds
  `SPT_ASSERT_NEXT(a_rsp_hold, stalled, rsp_valid && $stable(rsp_word))

  // only defined status codes leave the block
  `SPT_ASSERT_NOW(a_status_code, rsp_valid, status <= spt_pkg::ST_MISS)

  // words that name no slot carry zero slot fields
  `SPT_ASSERT_NOW(a_no_slot_zero, no_slot, slot_zero)

  // one request at a time: the scan starts right after accept
  `SPT_ASSERT_NEXT(a_one_in_flight, req_take, !req_ready)

endmodule

bind summary_prefix_table spt_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .status       (rsp.status),
  .entry_index  (rsp.entry_index),
  .entry_addr   (rsp.entry_addr),
  .entry_mask   (rsp.entry_mask),
  .entry_no_adv (rsp.entry_no_adv)
);
`default_nettype wire
